>>> rtl/dmq_pkg.sv
package dmq_pkg;

  localparam int MAX_RESULTS = 16;
  localparam int REL_W       = $clog2(MAX_RESULTS);

  typedef enum logic [0:0] {
    OP_SEND = 1'b0,
    OP_TICK = 1'b1
  } dmq_op_t;

  typedef enum logic [2:0] {
    KIND_NOW     = 3'd0,
    KIND_STORED  = 3'd1,
    KIND_DUP     = 3'd2,
    KIND_FULL    = 3'd3,
    KIND_DUE     = 3'd4
  } dmq_kind_t;

  typedef struct packed {
    dmq_op_t      opcode;
    logic [31:0]  now_time;
    logic [15:0]  delay_ticks;
    logic [7:0]   message_id;
    logic [7:0]   sender_code;
    logic [7:0]   receiver_code;
  } dmq_in_t;

  typedef struct packed {
    dmq_kind_t    kind;
    logic [7:0]   out_message;
    logic [7:0]   out_sender;
    logic [7:0]   out_receiver;
    logic         last;
  } dmq_out_t;

  typedef struct packed {
    logic [31:0]  due;
    logic [23:0]  ids;
  } dmq_entry_t;

  typedef struct packed {
    logic         load;
    logic         shift;
  } dmq_cell_ctl_t;

endpackage

>>> rtl/dmq_cell.sv
module dmq_cell import dmq_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  dmq_cell_ctl_t ctl,
  input  logic          nbr_valid,
  input  dmq_entry_t    nbr_entry,
  input  dmq_entry_t    new_entry,
  input  logic [23:0]   cmp_ids,
  input  logic [31:0]   cmp_now,
  output logic          valid,
  output dmq_entry_t    entry,
  output logic          match,
  output logic          due
);

  logic       valid_r;
  dmq_entry_t entry_r;
  logic [31:0] diff;

  // load takes a new message; shift pulls the upper neighbor down one place
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.load) begin
      valid_r <= 1'b1;
    end else if (ctl.shift) begin
      valid_r <= nbr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      entry_r <= new_entry;
    end else if (ctl.shift) begin
      entry_r <= nbr_entry;
    end
  end

  // wrap-safe: due when (due - now) as signed is zero or negative
  assign diff  = entry_r.due - cmp_now;
  assign due   = valid_r && ((diff == 32'd0) || diff[31]);
  assign match = valid_r && (entry_r.ids == cmp_ids);
  assign valid = valid_r;
  assign entry = entry_r;

endmodule

>>> rtl/delayed_message_queue_unit.sv
// Timed message queue with duplicate suppression.
//
// Input channel: drive in_item and raise start; the item is taken at the
// clock edge where start is high and busy is low. busy stays high while an
// item is being worked on.
// Result channel: each result shows on out_item for one cycle with out_valid
// high. The receiver cannot stall; every result must be taken as it comes.
//
// A send item gives exactly one result (delivered now, stored, duplicate
// dropped or full dropped); the item passes through the send state, and
// out_valid rises, registered, at the same edge at which busy falls.
// A tick item walks the chain of cells from the newest pending entry down to
// the oldest, one cell per cycle, then enters the flush state (directly
// when nothing is pending). Each due entry is removed as it is found,
// the cells above it shifting down one place. Hold each due result until the
// next due entry is found or the scan ends, then emit it; results come out
// newest first, the final one, marked by last, in the same cycle busy falls.
// At most sixteen entries are released per tick.
// Reset clears all valid flags and the entry count; nothing is pending.
module delayed_message_queue_unit import dmq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  dmq_in_t  in_item,
  output logic     out_valid,
  output dmq_out_t out_item
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SEND  = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  dmq_in_t           in_r;
  logic [CW-1:0]     count_r, count_nxt;
  logic [PW-1:0]     ptr_r, ptr_nxt;
  logic [REL_W-1:0]  rel_cnt_r, rel_cnt_nxt;
  logic              buf_vld_r, buf_vld_nxt;
  logic [23:0]       buf_ids_r, buf_ids_nxt;
  logic              out_valid_r, out_valid_nxt;
  dmq_out_t          out_item_r, out_item_nxt;

  logic              accept;
  logic              store_ok;
  logic              release_hit;
  logic              any_match;
  logic [23:0]       in_ids;
  dmq_entry_t        new_entry;

  logic              valid_w [DEPTH];
  dmq_entry_t        entry_w [DEPTH];
  logic [DEPTH-1:0]  match_w;
  logic [DEPTH-1:0]  due_w;
  dmq_cell_ctl_t     ctl_w   [DEPTH];

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign in_ids    = {in_r.message_id, in_r.sender_code, in_r.receiver_code};
  assign new_entry = '{due: in_r.now_time + {16'd0, in_r.delay_ticks}, ids: in_ids};
  assign any_match = |match_w;

  // a store happens only for a nonzero delay, no duplicate and a free cell
  assign store_ok    = (state_r == ST_SEND) && (in_r.delay_ticks != 16'd0) &&
                       !any_match && (count_r != CW'(DEPTH));
  assign release_hit = (state_r == ST_SCAN) && due_w[ptr_r];

  // chain of cells, oldest entry at index 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic       nbr_valid;
    dmq_entry_t nbr_entry;

    if (i < DEPTH - 1) begin : g_mid
      assign nbr_valid = valid_w[i+1];
      assign nbr_entry = entry_w[i+1];
    end else begin : g_top
      assign nbr_valid = 1'b0;
      assign nbr_entry = '0;
    end

    // load the first free cell; on a release shift every cell at or above it
    assign ctl_w[i].load  = store_ok && (CW'(i) == count_r);
    assign ctl_w[i].shift = release_hit && (PW'(i) >= ptr_r);

    dmq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl_w[i]),
      .nbr_valid (nbr_valid),
      .nbr_entry (nbr_entry),
      .new_entry (new_entry),
      .cmp_ids   (in_ids),
      .cmp_now   (in_r.now_time),
      .valid     (valid_w[i]),
      .entry     (entry_w[i]),
      .match     (match_w[i]),
      .due       (due_w[i])
    );
  end

  // capture the item on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_item;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    rel_cnt_nxt   = rel_cnt_r;
    buf_vld_nxt   = buf_vld_r;
    buf_ids_nxt   = buf_ids_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          rel_cnt_nxt = '0;
          buf_vld_nxt = 1'b0;
          if (in_item.opcode == OP_SEND) begin
            state_nxt = ST_SEND;
          end else if (count_r == '0) begin
            // nothing pending: flush finds an empty buffer
            state_nxt = ST_FLUSH;
          end else begin
            ptr_nxt   = PW'(count_r - CW'(1));
            state_nxt = ST_SCAN;
          end
        end
      end

      ST_SEND: begin
        out_valid_nxt            = 1'b1;
        out_item_nxt.out_message  = in_r.message_id;
        out_item_nxt.out_sender   = in_r.sender_code;
        out_item_nxt.out_receiver = in_r.receiver_code;
        out_item_nxt.last         = 1'b1;
        // duplicate check ranks ahead of the full check
        if (in_r.delay_ticks == 16'd0) begin
          out_item_nxt.kind = KIND_NOW;
        end else if (any_match) begin
          out_item_nxt.kind = KIND_DUP;
        end else if (count_r == CW'(DEPTH)) begin
          out_item_nxt.kind = KIND_FULL;
        end else begin
          out_item_nxt.kind = KIND_STORED;
          count_nxt         = count_r + CW'(1);
        end
        state_nxt = ST_IDLE;
      end

      ST_SCAN: begin
        if (release_hit) begin
          // emit the held result, hold the new one until the next is known
          if (buf_vld_r) begin
            out_valid_nxt             = 1'b1;
            out_item_nxt.kind         = KIND_DUE;
            out_item_nxt.out_message  = buf_ids_r[23:16];
            out_item_nxt.out_sender   = buf_ids_r[15:8];
            out_item_nxt.out_receiver = buf_ids_r[7:0];
            out_item_nxt.last         = 1'b0;
          end
          buf_vld_nxt = 1'b1;
          buf_ids_nxt = entry_w[ptr_r].ids;
          count_nxt   = count_r - CW'(1);
          rel_cnt_nxt = rel_cnt_r + REL_W'(1);
        end
        if ((ptr_r == '0) ||
            (release_hit && (rel_cnt_r == REL_W'(MAX_RESULTS - 1)))) begin
          state_nxt = ST_FLUSH;
        end else begin
          ptr_nxt = ptr_r - PW'(1);
        end
      end

      ST_FLUSH: begin
        if (buf_vld_r) begin
          out_valid_nxt             = 1'b1;
          out_item_nxt.kind         = KIND_DUE;
          out_item_nxt.out_message  = buf_ids_r[23:16];
          out_item_nxt.out_sender   = buf_ids_r[15:8];
          out_item_nxt.out_receiver = buf_ids_r[7:0];
          out_item_nxt.last         = 1'b1;
        end
        buf_vld_nxt = 1'b0;
        state_nxt   = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      ptr_r       <= '0;
      rel_cnt_r   <= '0;
      buf_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ptr_r       <= ptr_nxt;
      rel_cnt_r   <= rel_cnt_nxt;
      buf_vld_r   <= buf_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_ids_r  <= buf_ids_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
